// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the line accumulator of the record checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/ihrc_pkg.sv =====
// Types, constants and helper functions of the HEX record line checker.
package ihrc_pkg;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX   = 10'd1023;
  localparam logic [POS_W-1:0] MAX_LINE  = 10'd521;
  localparam logic [POS_W-1:0] MIN_LINE  = 10'd11;
  localparam logic [POS_W-1:0] EXT_LINE  = 10'd15;
  localparam logic [POS_W-1:0] LIN_LINE  = 10'd19;
  localparam logic [POS_W-1:0] TYPE_HI_POS = 10'd7;
  localparam logic [POS_W-1:0] TYPE_LO_POS = 10'd8;
  localparam logic [POS_W-1:0] CK_OFS_COLON = 10'd9;
  localparam logic [POS_W-1:0] CK_OFS_BARE  = 10'd8;
  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] TYPE_MAX   = 8'd5;

  localparam int unsigned OUT_DATA_W = 40;

  // Record types
  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;
  localparam logic [7:0] REC_ESA  = 8'd2;
  localparam logic [7:0] REC_SSA  = 8'd3;
  localparam logic [7:0] REC_ELA  = 8'd4;
  localparam logic [7:0] REC_SLA  = 8'd5;

  typedef enum logic [2:0] {
    FAIL_NONE     = 3'd0,
    FAIL_LENGTH   = 3'd1,
    FAIL_COLON    = 3'd2,
    FAIL_TYPE     = 3'd3,
    FAIL_MISMATCH = 3'd4
  } fail_e;

  // Decoded character held in the input stage
  typedef struct packed {
    logic [3:0] digit;
    logic       colon;
    logic       last;
  } char_t;

  // Line totals as they stand after the current character
  typedef struct packed {
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] ck_pos;
    logic             colon;
    logic [7:0]       len;
    logic [7:0]       typ;
    logic [7:0]       sum;
    logic [7:0]       ck;
  } line_sum_t;

  // Hex digit in either case to nibble, anything else to zero
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    logic [7:0] r;
    v = c - 8'd48;
    r = 8'd0;
    if (v <= 8'd9) begin
      r = v;
    end else if (v inside {[8'd17:8'd22]}) begin
      r = v - 8'd7;
    end else if (v inside {[8'd49:8'd54]}) begin
      r = v - 8'd39;
    end
    return r[3:0];
  endfunction

endpackage

// ===== rtl/core/intel_hex_record_checker.sv =====
// Top level of the HEX record line checker.
//
//  Channel   Dir  Content                               Marker
//  s_axis    in   one line character per transaction    tlast = final character
//  m_axis    out  line verdict and checksums            one per line
//
// Each character is held in the input register; a line-end character then
// loads the result register as it moves on. Sustained rate is one
// character per cycle unless a line-end character waits on an untaken
// verdict. The result register frees the input side while a verdict
// waits; only a line-end character stalls behind an untaken verdict.
// Reset (rst_ni low) clears the line position, colon flag and both valid bits.
module intel_hex_record_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  logic        s_axis_tlast_i,   // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] line_ok, [3:1] fail_code, [4] calc_valid, [12:5] calc_sum,
  // [13] read_valid, [21:14] read_sum, [22] sums_match,
  // [30:23] record_kind, [38:31] data_count, [39] zero
  output logic [ihrc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import ihrc_pkg::*;

  logic      adv;
  logic      out_free;
  char_t     in_char;
  line_sum_t line_sum;

  ihrc_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .out_free_i      (out_free),
    .adv_o           (adv),
    .char_o          (in_char)
  );

  ihrc_line_acc u_line_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (in_char),
    .sum_o  (line_sum)
  );

  ihrc_verdict u_verdict (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (adv && in_char.last),
    .sum_i           (line_sum),
    .out_free_o      (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== rtl/core/ihrc_in_stage.sv =====
// Input register: takes one character per transaction and decodes it.
module ihrc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [7:0]     s_axis_tdata_i,   // [7:0] char_in
  input  logic           s_axis_tlast_i,
  input  logic           out_free_i,
  output logic           adv_o,
  output ihrc_pkg::char_t char_o
);
  import ihrc_pkg::*;

  logic  valid_q;
  logic  valid_d;
  char_t char_q;

  // A held character moves on unless it ends a line and the result slot is full
  assign adv_o           = valid_q && (!char_q.last || out_free_i);
  assign s_axis_tready_o = !valid_q || adv_o;
  assign char_o          = char_q;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready_o) begin
      valid_d = s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: decoded nibble, colon flag, line end
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      char_q.digit <= digit_value(s_axis_tdata_i);
      char_q.colon <= (s_axis_tdata_i == COLON_CHAR);
      char_q.last  <= s_axis_tlast_i;
    end
  end

endmodule

// ===== rtl/core/ihrc_line_acc.sv =====
// Per-line state: position, colon, length, type, checksum digits, byte sum.
`include "assert_macros.svh"

module ihrc_line_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  ihrc_pkg::char_t     in_i,
  output ihrc_pkg::line_sum_t sum_o
);
  import ihrc_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             colon_q, colon_d;
  logic [3:0]       hi_q, hi_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       typ_q, typ_d;
  logic [7:0]       ck_q, ck_d;

  logic             first;
  logic [POS_W-1:0] start;
  logic [3:0]       hi_b;
  logic [7:0]       sum_b, len_b, typ_b, ck_b;
  logic [POS_W-1:0] ck_pos;
  logic [POS_W-1:0] n;

  // Update for the character in the input stage
  always_comb begin
    first   = (pos_q == '0);
    colon_d = first ? in_i.colon : colon_q;
    hi_b    = first ? 4'd0 : hi_q;
    sum_b   = first ? 8'd0 : sum_q;
    len_b   = first ? 8'd0 : len_q;
    typ_b   = first ? 8'd0 : typ_q;
    ck_b    = first ? 8'd0 : ck_q;
    start   = {{(POS_W-1){1'b0}}, colon_d};

    // length byte
    len_d = len_b;
    if (pos_q == start) begin
      len_d = {in_i.digit, 4'd0};
    end else if (pos_q == start + 10'd1) begin
      len_d = {len_b[7:4], in_i.digit};
    end

    // record type byte
    typ_d = typ_b;
    if (pos_q == TYPE_HI_POS) begin
      typ_d = {in_i.digit, 4'd0};
    end else if (pos_q == TYPE_LO_POS) begin
      typ_d = {typ_b[7:4], in_i.digit};
    end

    // checksum position follows the length just updated
    ck_pos = {1'b0, len_d, 1'b0} + (colon_d ? CK_OFS_COLON : CK_OFS_BARE);

    ck_d = ck_b;
    if (pos_q == ck_pos) begin
      ck_d = {in_i.digit, 4'd0};
    end else if (pos_q == ck_pos + 10'd1) begin
      ck_d = {ck_b[7:4], in_i.digit};
    end

    // byte sum over nibble pairs ahead of the checksum
    hi_d  = hi_b;
    sum_d = sum_b;
    if (pos_q >= start && pos_q != POS_MAX) begin
      if (!(pos_q[0] ^ colon_d)) begin
        hi_d = in_i.digit;
      end else if (pos_q - 10'd1 < ck_pos) begin
        sum_d = sum_b + {hi_b, in_i.digit};
      end
    end

    n     = (pos_q == POS_MAX) ? POS_MAX : pos_q + 10'd1;
    pos_d = in_i.last ? '0 : n;
  end

  assign sum_o = '{n: n, ck_pos: ck_pos, colon: colon_d, len: len_d, typ: typ_d,
                   sum: sum_d, ck: ck_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      colon_q <= 1'b0;
    end else if (adv_i) begin
      pos_q   <= pos_d;
      colon_q <= in_i.last ? 1'b0 : colon_d;
    end
  end

  // Payload; cleared in effect at each line start
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hi_q  <= hi_d;
      sum_q <= sum_d;
      len_q <= len_d;
      typ_q <= typ_d;
      ck_q  <= ck_d;
    end
  end

  `ASSERT_CHK(a_pos_clr_at_end, adv_i && in_i.last |=> pos_q == '0, "pos not cleared at line end")
  `ASSERT_CHK(a_pos_step, adv_i && !in_i.last && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 10'd1, "pos did not advance")
  `ASSERT_CHK(a_colon_hold, adv_i && !in_i.last && pos_q != '0 |=> colon_q == $past(colon_q), "colon flag changed mid-line")
  `ASSERT_RST(a_reset_state, !rst_ni |-> pos_q == '0 && !colon_q, "line state not cleared by reset")

endmodule

// ===== rtl/core/ihrc_verdict.sv =====
// Line-end verdict and output register with its stream handshake.
module ihrc_verdict (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  ihrc_pkg::line_sum_t          sum_i,
  output logic                         out_free_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [ihrc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import ihrc_pkg::*;

  fail_e      fail;
  logic       cv, rv;
  logic [7:0] cs, rs;
  logic       valid_q, valid_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;

  // Checksum availability and values
  always_comb begin
    cv = ({1'b0, sum_i.ck_pos} <= {1'b0, sum_i.n});
    rv = ({1'b0, sum_i.ck_pos} + 11'd2 <= {1'b0, sum_i.n});
    cs = cv ? 8'd0 - sum_i.sum : 8'd0;
    rs = rv ? sum_i.ck : 8'd0;
  end

  // Format rules, first failing rule wins
  always_comb begin
    fail = FAIL_NONE;
    if (!sum_i.n[0] || sum_i.n > MAX_LINE || sum_i.n < MIN_LINE) begin
      fail = FAIL_LENGTH;
    end else if (!sum_i.colon) begin
      fail = FAIL_COLON;
    end else if (sum_i.typ > TYPE_MAX) begin
      fail = FAIL_TYPE;
    end else if (sum_i.typ == REC_DATA) begin
      if ({1'b0, sum_i.len, 1'b0} + MIN_LINE != sum_i.n) fail = FAIL_MISMATCH;
    end else if (sum_i.typ == REC_EOF) begin
      if (sum_i.len != 8'd0 || sum_i.n != MIN_LINE) fail = FAIL_MISMATCH;
    end else if (sum_i.typ inside {REC_ESA, REC_ELA}) begin
      if (sum_i.len != 8'd2 || sum_i.n != EXT_LINE) fail = FAIL_MISMATCH;
    end else begin
      if (sum_i.len != 8'd4 || sum_i.n != LIN_LINE) fail = FAIL_MISMATCH;
    end
  end

  // Pack result fields, lowest bit first
  always_comb begin
    data_d = {1'b0, sum_i.len, sum_i.typ, (cv && rv && cs == rs), rs, rv, cs, cv,
              fail, (fail == FAIL_NONE)};
  end

  // Output slot handshake
  assign out_free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule
